### sv/tank_fill_controller_macros.svh
// ----------------------------------------------------------------------------
// tank_fill_controller_macros
// assertion macros used by the tank fill controller sequencer
// ----------------------------------------------------------------------------
`ifndef TANK_FILL_CONTROLLER_MACROS_SVH
`define TANK_FILL_CONTROLLER_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, checked out of reset
`define TFC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tfc assertion failed");
// next-cycle implication, checked out of reset
`define TFC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tfc assertion failed");
`else
`define TFC_ASSERT_IMP(lbl, ante, cons)
`define TFC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### sv/tfc_pkg.sv
// ----------------------------------------------------------------------------
// tfc_pkg
// types and codes shared by the tank fill controller modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tfc_pkg;

  localparam int unsigned VOL_W  = 26;
  localparam int unsigned TMR_W  = 25;
  localparam int unsigned MS_W   = 24;
  localparam int unsigned FAC_W  = 16;
  localparam int unsigned CFG_W  = 26;
  localparam int unsigned CFG_IDX_W = 3;

  // item opcodes
  localparam logic [1:0] OP_TICK       = 2'd0;
  localparam logic [1:0] OP_FILL       = 2'd1;
  localparam logic [1:0] OP_SET_ACTIVE = 2'd2;

  // fault codes
  localparam logic [1:0] FLT_NONE    = 2'd0;
  localparam logic [1:0] FLT_NO_FILL = 2'd1;
  localparam logic [1:0] FLT_STOPPED = 2'd2;
  localparam logic [1:0] FLT_TIMEOUT = 2'd3;

  // command error codes
  localparam logic [2:0] ERR_OK         = 3'd0;
  localparam logic [2:0] ERR_NO_SOURCE  = 3'd1;
  localparam logic [2:0] ERR_INACTIVE   = 3'd2;
  localparam logic [2:0] ERR_FULL       = 3'd3;
  localparam logic [2:0] ERR_SOURCE_OFF = 3'd4;
  localparam logic [2:0] ERR_CANNOT_EN  = 3'd5;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRESSURE_FACTOR  = 3'd0,
    CFG_VOLUME_FACTOR    = 3'd1,
    CFG_MAX_VOLUME       = 3'd2,
    CFG_MIN_VOLUME       = 3'd3,
    CFG_CHANGE_THRESHOLD = 3'd4,
    CFG_MAX_IDLE_MS      = 3'd5,
    CFG_SETTLE_MS        = 3'd6,
    CFG_HAS_SOURCE       = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        command_value;
    logic [9:0]  raw_pressure;
    logic [15:0] elapsed_ms;
    logic        pump_feedback;
    logic        source_active;
    logic        source_can_enable;
  } tfc_in_t;

  typedef struct packed {
    logic             pump_drive;
    logic             tank_active;
    logic [1:0]       fault_code;
    logic [2:0]       command_error;
    logic [VOL_W-1:0] volume;
  } tfc_out_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRES,
    ST_VOL,
    ST_EXEC
  } tfc_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic pres;
    logic vol;
    logic exec;
  } tfc_cmd_t;

endpackage

### sv/tfc_dp.sv
// ----------------------------------------------------------------------------
// tfc_dp
// datapath: config registers, two multiply stages, tank state and result reg
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfc_dp
  import tfc_pkg::*;
#(
  parameter int unsigned LOCKOUT_MS = 5000
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  tfc_in_t              in_data,
  input  tfc_cmd_t             cmd,
  output tfc_out_t             out_data
);

  localparam logic [TMR_W-1:0] LOCKOUT_T = TMR_W'(LOCKOUT_MS);

  // saturating timer add
  function automatic logic [TMR_W-1:0] tsat(input logic [TMR_W-1:0] t,
                                            input logic [15:0] d);
    logic [TMR_W:0] s;
    s = {1'b0, t} + {{(TMR_W-15){1'b0}}, d};
    tsat = s[TMR_W] ? {TMR_W{1'b1}} : s[TMR_W-1:0];
  endfunction

  // configuration registers
  logic [FAC_W-1:0] pf_r, vf_r;
  logic [VOL_W-1:0] max_vol_r, min_vol_r, thr_r;
  logic [MS_W-1:0]  idle_r, settle_r;
  logic             has_src_r;

  // item pipeline registers
  tfc_in_t          in_r;
  logic [VOL_W-1:0] pres_r, pres_nxt;
  logic [VOL_W-1:0] vol_r, vol_nxt;
  logic [41:0]      vprod;
  logic [TMR_W-1:0] fill_add_r, chg_add_r, lock_add_r;
  logic             diff_ge_r, diff_ge_nxt;
  logic [VOL_W-1:0] diff;
  tfc_out_t         out_r, out_nxt;

  // tank state
  logic             active_r, active_nxt;
  logic             pump_r, pump_nxt;
  logic [VOL_W-1:0] last_r, last_nxt;
  logic [1:0]       fault_r, fault_nxt;
  logic [TMR_W-1:0] fill_r, fill_nxt;
  logic             frun_r, frun_nxt;
  logic [TMR_W-1:0] chg_r, chg_nxt;
  logic             crun_r, crun_nxt;
  logic [TMR_W-1:0] lock_r, lock_nxt;

  // execute-step temporaries
  logic             on_v, do_start, start_force, can_fill;
  logic [TMR_W-1:0] t_sel;
  logic [1:0]       fout;
  logic [2:0]       err;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pf_r      <= FAC_W'(256);
      vf_r      <= FAC_W'(256);
      max_vol_r <= '0;
      min_vol_r <= '0;
      thr_r     <= '0;
      idle_r    <= MS_W'(60000);
      settle_r  <= MS_W'(10000);
      has_src_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_PRESSURE_FACTOR:  pf_r      <= cfg_wdata[FAC_W-1:0];
        CFG_VOLUME_FACTOR:    vf_r      <= cfg_wdata[FAC_W-1:0];
        CFG_MAX_VOLUME:       max_vol_r <= cfg_wdata[VOL_W-1:0];
        CFG_MIN_VOLUME:       min_vol_r <= cfg_wdata[VOL_W-1:0];
        CFG_CHANGE_THRESHOLD: thr_r     <= cfg_wdata[VOL_W-1:0];
        CFG_MAX_IDLE_MS:      idle_r    <= cfg_wdata[MS_W-1:0];
        CFG_SETTLE_MS:        settle_r  <= cfg_wdata[MS_W-1:0];
        CFG_HAS_SOURCE:       has_src_r <= cfg_wdata[0];
      endcase
    end
  end

  // stage 1: raw sample to pressure
  assign pres_nxt = VOL_W'(in_r.raw_pressure) * VOL_W'(pf_r);

  // stage 2: pressure to volume, timer advance and rise check
  assign vprod   = 42'(pres_r) * 42'(vf_r);
  assign vol_nxt = vprod[41:16];
  assign diff    = (pres_r > last_r) ? pres_r - last_r : last_r - pres_r;
  assign diff_ge_nxt = diff >= thr_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_r <= in_data;
    end
    if (cmd.pres) begin
      pres_r <= pres_nxt;
    end
    if (cmd.vol) begin
      vol_r      <= vol_nxt;
      diff_ge_r  <= diff_ge_nxt;
      fill_add_r <= frun_r ? tsat(fill_r, in_r.elapsed_ms) : fill_r;
      chg_add_r  <= crun_r ? tsat(chg_r, in_r.elapsed_ms) : chg_r;
      lock_add_r <= tsat(lock_r, in_r.elapsed_ms);
    end
    if (cmd.exec) begin
      out_r <= out_nxt;
    end
  end

  // stage 3: control decisions for one item
  always_comb begin
    active_nxt  = active_r;
    pump_nxt    = pump_r;
    last_nxt    = last_r;
    fault_nxt   = fault_r;
    fill_nxt    = fill_add_r;
    frun_nxt    = frun_r;
    chg_nxt     = chg_add_r;
    crun_nxt    = crun_r;
    lock_nxt    = lock_add_r;
    on_v        = in_r.pump_feedback;
    do_start    = 1'b0;
    start_force = 1'b0;
    can_fill    = 1'b0;
    t_sel       = '0;
    fout        = FLT_NONE;
    err         = ERR_OK;

    case (in_r.opcode)
      OP_TICK: begin
        if (has_src_r) begin
          // rise supervision while the pump runs
          if (active_r && on_v) begin
            fault_nxt = FLT_NONE;
            if (diff_ge_r) begin
              chg_nxt  = '0;
              crun_nxt = 1'b1;
            end else begin
              t_sel = crun_r ? chg_add_r : (frun_r ? fill_add_r : '0);
              if (t_sel >= {1'b0, idle_r}) begin
                fault_nxt  = FLT_TIMEOUT;
                active_nxt = 1'b0;
                pump_nxt   = 1'b0;
                on_v       = 1'b0;
              end else if (t_sel >= {1'b0, settle_r}) begin
                fault_nxt = crun_r ? FLT_STOPPED : FLT_NO_FILL;
              end
            end
            last_nxt = pres_r;
          end
          // switching after lockout
          if (lock_add_r > LOCKOUT_T) begin
            can_fill = in_r.source_can_enable && active_nxt && (vol_r < max_vol_r);
            if (!can_fill && on_v) begin
              pump_nxt = 1'b0;
              lock_nxt = '0;
            end else if (can_fill && (vol_r <= min_vol_r) && !on_v) begin
              do_start = 1'b1;
            end
          end
          fout = fault_nxt;
        end
      end
      OP_FILL: begin
        if (!has_src_r) begin
          err = ERR_NO_SOURCE;
        end else if (!in_r.command_value && !active_r) begin
          err = ERR_INACTIVE;
        end else if (!in_r.command_value && (vol_r >= max_vol_r)) begin
          err = ERR_FULL;
        end else begin
          do_start    = 1'b1;
          start_force = in_r.command_value;
        end
      end
      OP_SET_ACTIVE: begin
        active_nxt = in_r.command_value;
        if (!in_r.command_value && has_src_r) begin
          pump_nxt = 1'b0;
        end
      end
      default: ;
    endcase

    // fill start
    if (do_start) begin
      active_nxt = 1'b1;
      fill_nxt   = '0;
      frun_nxt   = 1'b1;
      lock_nxt   = '0;
      chg_nxt    = '0;
      crun_nxt   = 1'b0;
      last_nxt   = pres_r;
      if (!start_force && !in_r.source_active) begin
        err = ERR_SOURCE_OFF;
      end else if (!start_force && !in_r.source_can_enable) begin
        err = ERR_CANNOT_EN;
      end else begin
        pump_nxt = 1'b1;
      end
    end

    out_nxt.pump_drive    = pump_nxt;
    out_nxt.tank_active   = active_nxt;
    out_nxt.fault_code    = fout;
    out_nxt.command_error = err;
    out_nxt.volume        = vol_r;
  end

  // tank state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b1;
      pump_r   <= 1'b0;
      last_r   <= '0;
      fault_r  <= FLT_NONE;
      fill_r   <= '0;
      frun_r   <= 1'b0;
      chg_r    <= '0;
      crun_r   <= 1'b0;
      lock_r   <= '0;
    end else if (cmd.exec) begin
      active_r <= active_nxt;
      pump_r   <= pump_nxt;
      last_r   <= last_nxt;
      fault_r  <= fault_nxt;
      fill_r   <= fill_nxt;
      frun_r   <= frun_nxt;
      chg_r    <= chg_nxt;
      crun_r   <= crun_nxt;
      lock_r   <= lock_nxt;
    end
  end

  assign out_data = out_r;

endmodule

### sv/tfc_ctrl.sv
// ----------------------------------------------------------------------------
// tfc_ctrl
// sequencer: steps each transaction through the datapath and owns out valid
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tank_fill_controller_macros.svh"

module tfc_ctrl
  import tfc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output tfc_cmd_t cmd
);

  tfc_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_free = !out_valid_r || out_ready;

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_ready    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = ST_PRES;
        end
      end
      ST_PRES: begin
        cmd.pres  = 1'b1;
        state_nxt = ST_VOL;
      end
      ST_VOL: begin
        cmd.vol   = 1'b1;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
    endcase
    out_valid_nxt = cmd.exec ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  assign out_valid = out_valid_r;

  `TFC_ASSERT_IMP(a_exec_needs_room, cmd.exec, (!out_valid_r || out_ready))
  `TFC_ASSERT_NXT(a_accept_starts, (in_valid && in_ready), (state_r == ST_PRES))
  `TFC_ASSERT_NXT(a_exec_shows_result, cmd.exec, out_valid_r)
  `TFC_ASSERT_NXT(a_result_held, (out_valid_r && !out_ready), out_valid_r)
  `TFC_ASSERT_IMP(a_one_command, 1'b1, $onehot0(cmd))

endmodule

### sv/tank_fill_controller.sv
// ----------------------------------------------------------------------------
// tank_fill_controller
// pump controller for a pressure-measured tank with fault supervision
// each transaction steps through the capture, the two multiply stages and the
//   decision step one after the other; the decision step waits while a result
//   is not yet taken from the output, and then the next transaction is accepted
// the next input transaction is taken while a result waits on the output
// reset: synchronous active-low rst_n restores config and tank state defaults
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tank_fill_controller
  import tfc_pkg::*;
#(
  parameter int unsigned LOCKOUT_MS = 5000
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tfc_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tfc_out_t             out_data
);

  tfc_cmd_t cmd;

  // sequencer
  tfc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // datapath
  tfc_dp #(
    .LOCKOUT_MS (LOCKOUT_MS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_data  (out_data)
  );

endmodule
